// File: sv/joint_target_sequencer_top_defines.svh
// Assertion macros for the joint target sequencer
`ifndef JOINT_TARGET_SEQUENCER_TOP_DEFINES_SVH
`define JOINT_TARGET_SEQUENCER_TOP_DEFINES_SVH

// Implication checked on every clock, quiet in reset
`define JTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication
`define JTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: sv/jts_pkg.sv
// ----------------------------------------------------------------------------
// jts_pkg
// Types and constants shared by the joint target sequencer modules.
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam int JOINTS = 25;
    localparam int JW     = 5;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_CAPTURE = 2'd1;
    localparam logic [1:0] OP_BEGIN   = 2'd2;
    localparam logic [1:0] OP_JOINT   = 2'd3;

    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_RAMP   = 2'd1;
    localparam logic [1:0] MODE_POLICY = 2'd2;
    localparam logic [1:0] MODE_FROZEN = 2'd3;

    localparam logic [2:0] REG_SCALE  = 3'd0;
    localparam logic [2:0] REG_STEP   = 3'd1;
    localparam logic [2:0] REG_TILT   = 3'd2;
    localparam logic [2:0] REG_TICKS  = 3'd3;
    localparam logic [2:0] REG_PERIOD = 3'd4;

    // divider request / response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [15:0] remainder;
    } div_rsp_t;

endpackage

// File: sv/jts_ram.sv
// ----------------------------------------------------------------------------
// jts_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module jts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 25
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/jts_div.sv
// ----------------------------------------------------------------------------
// jts_div
// Bit-serial restoring divider, 32 by 16 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jts_div
    import jts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [16:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;

    // one shift-subtract step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {2'b00, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                rem_next = trial[16:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[15:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    // remainder is below the divisor once done
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[15:0];

endmodule

// File: sv/jts_mul.sv
// ----------------------------------------------------------------------------
// jts_mul
// Serial shift-add multiplier, 16 by 16 bits unsigned, one bit per cycle.
// ----------------------------------------------------------------------------
module jts_mul
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic        done,
    output logic [31:0] product
);

    logic [31:0] acc_reg, acc_next;
    logic [31:0] mcd_reg, mcd_next;
    logic [15:0] mpl_reg, mpl_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    // add shifted multiplicand for each multiplier bit
    always_comb
    begin
        acc_next  = acc_reg;
        mcd_next  = mcd_reg;
        mpl_next  = mpl_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mcd_next  = {16'd0, a};
            mpl_next  = b;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mpl_reg[0])
            begin
                acc_next = acc_reg + mcd_reg;
            end
            mcd_next = {mcd_reg[30:0], 1'b0};
            mpl_next = {1'b0, mpl_reg[15:1]};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcd_reg <= mcd_next;
        mpl_reg <= mpl_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: sv/joint_target_sequencer_top.sv
// ----------------------------------------------------------------------------
// joint_target_sequencer_top
// Per-joint position-target sequencer: init, ramp, policy and frozen modes.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | contents
// s_axis  | in  | s_axis_tvalid/tready   | one request: op, indexes, pose, action
// m_axis  | out | m_axis_tvalid/tready   | one result per request
// cfg     | in  | cfg_valid/cfg_ready    | register index and write data
//
// A request is accepted in idle and passes the READ1, READ2, CALC, FIN and OUT
// states, with a WAIT state between CALC and FIN while a serial unit runs. A
// policy-due joint waits on the multiplier, a tick begin in policy mode on the
// divider for the period step, a ramp joint on both in series.
// Reset clears mode and counters; pose stores are undefined until written.
// A result not yet taken holds the next request at its finish step.
module joint_target_sequencer_top
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: operation[1:0], policy_index[6:2], ctrl_index[11:7],
    // position[27:12], action[43:28], gravity_z[59:44], zero fill [63:60]
    input  logic [63:0] s_axis_tdata,
    // tuser: estop[0], imu_valid[1]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: mode[1:0], joint_out_index[6:2], target_position[22:7], fill
    output logic [23:0] m_axis_tdata,
    // tuser: policy_due[0], target_valid[1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ1 = 7'b0000010,
        ST_READ2 = 7'b0000100,
        ST_CALC  = 7'b0001000,
        ST_WAIT  = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] scale_reg;
    logic [14:0] step_reg;
    logic signed [15:0] tilt_reg;
    logic [15:0] ticks_reg;
    logic [7:0]  period_reg;

    // control state
    logic [1:0]  run_mode_reg, tick_kind_reg;
    logic        tick_due_reg, freeze_entry_reg;
    logic [15:0] ramp_count_reg;
    logic [7:0]  period_count_reg;

    // captured request
    logic [1:0]  op_reg;
    logic [4:0]  p_reg, c_reg, m_reg;
    logic signed [15:0] pos_reg, act_reg, gz_reg;
    logic        estop_reg, imu_reg, last_reg;

    // result register
    logic        ovalid_reg;
    logic [1:0]  omode_reg;
    logic        odue_reg, ovld_reg, olast_reg;
    logic [4:0]  oidx_reg;
    logic signed [15:0] otgt_reg;

    // memories
    logic        def_we, map_we, cap_we, held_we, frz_we;
    logic [4:0]  def_wa, map_wa, cap_wa, held_wa, frz_wa;
    logic [4:0]  def_ra, map_ra, cap_ra, held_ra, frz_ra;
    logic [15:0] def_wd, cap_wd, held_wd, frz_wd;
    logic [4:0]  map_wd;
    logic [15:0] def_rd, cap_rd, held_rd, frz_rd;
    logic [4:0]  map_rd;

    jts_ram #(.WIDTH(16), .DEPTH(JOINTS)) u_def (.clk, .we(def_we), .waddr(def_wa),
        .wdata(def_wd), .raddr(def_ra), .rdata(def_rd));
    jts_ram #(.WIDTH(5), .DEPTH(JOINTS)) u_map (.clk, .we(map_we), .waddr(map_wa),
        .wdata(map_wd), .raddr(map_ra), .rdata(map_rd));
    jts_ram #(.WIDTH(16), .DEPTH(JOINTS)) u_cap (.clk, .we(cap_we), .waddr(cap_wa),
        .wdata(cap_wd), .raddr(cap_ra), .rdata(cap_rd));
    jts_ram #(.WIDTH(16), .DEPTH(JOINTS)) u_held (.clk, .we(held_we), .waddr(held_wa),
        .wdata(held_wd), .raddr(held_ra), .rdata(held_rd));
    jts_ram #(.WIDTH(16), .DEPTH(JOINTS)) u_frz (.clk, .we(frz_we), .waddr(frz_wa),
        .wdata(frz_wd), .raddr(frz_ra), .rdata(frz_rd));

    // serial units
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        mstart, mdone;
    logic [31:0] mprod;
    logic [15:0] ma, mb;

    jts_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));
    jts_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .done(mdone),
        .product(mprod));

    // working values
    logic [15:0] cap_q_reg, def_q_reg, held_q_reg;
    logic        neg_reg;
    logic        p_ok, c_ok;
    logic signed [16:0] diff_w;
    logic [15:0] mag_w;
    logic [15:0] ticks_eff;
    logic [7:0]  per_eff;
    logic signed [15:0] tgt_w;
    logic [1:0]  kind_w;
    logic        due_w;
    logic [4:0]  m_w;
    logic        out_free, fin_fire;
    logic        begin_div_w, use_div_w;

    assign p_ok = p_reg < 5'(JOINTS);
    assign c_ok = c_reg < 5'(JOINTS);
    assign ticks_eff = (ticks_reg == 16'd0) ? 16'd1 : ticks_reg;
    assign per_eff   = (period_reg == 8'd0) ? 8'd1 : period_reg;
    assign m_w       = (map_rd < 5'(JOINTS)) ? map_rd : 5'd0;

    // finish step waits for a free result register
    assign out_free  = !ovalid_reg || m_axis_tready;
    assign fin_fire  = (state_reg == ST_FIN) && out_free;

    // tick begin in policy steps period_count through the divider
    assign begin_div_w = (op_reg == OP_BEGIN) && (run_mode_reg == MODE_POLICY);
    assign use_div_w   = (op_reg == OP_BEGIN) || (tick_kind_reg == MODE_RAMP);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE) && !s_axis_tvalid;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= 16'd16384;
            step_reg   <= 15'd410;
            tilt_reg   <= -16'sd4915;
            ticks_reg  <= 16'd200;
            period_reg <= 8'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE:  scale_reg  <= cfg_data;
                REG_STEP:   step_reg   <= cfg_data[14:0];
                REG_TILT:   tilt_reg   <= cfg_data;
                REG_TICKS:  ticks_reg  <= cfg_data;
                REG_PERIOD: period_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // memory addressing
    always_comb
    begin
        def_we  = 1'b0;
        map_we  = 1'b0;
        cap_we  = 1'b0;
        held_we = 1'b0;
        frz_we  = 1'b0;
        def_wa  = p_reg;
        map_wa  = p_reg;
        cap_wa  = c_reg;
        held_wa = c_reg;
        frz_wa  = c_reg;
        def_wd  = pos_reg;
        map_wd  = c_reg;
        cap_wd  = pos_reg;
        held_wd = pos_reg;
        frz_wd  = pos_reg;
        map_ra  = p_ok ? p_reg : 5'd0;
        def_ra  = map_ra;
        // map data arrives in READ2; address the pose stores with it directly
        cap_ra  = (state_reg == ST_READ2) ? m_w : m_reg;
        held_ra = cap_ra;
        frz_ra  = cap_ra;
        if (state_reg == ST_READ1)
        begin
            if (op_reg == OP_LOAD && p_ok && c_ok)
            begin
                def_we = 1'b1;
                map_we = 1'b1;
            end
            if (op_reg == OP_CAPTURE && c_ok)
            begin
                cap_we  = 1'b1;
                held_we = 1'b1;
                frz_we  = 1'b1;
            end
        end
        if (fin_fire && op_reg == OP_JOINT && p_ok)
        begin
            held_wa = m_reg;
            frz_wa  = m_reg;
            held_wd = tgt_w;
            frz_wd  = held_q_reg;
            held_we = (tick_kind_reg == MODE_RAMP)
                   || (tick_kind_reg == MODE_POLICY && tick_due_reg);
            frz_we  = (tick_kind_reg == MODE_FROZEN) && freeze_entry_reg;
        end
    end

    // target arithmetic on the final step
    logic signed [31:0] scaled_w;
    logic signed [20:0] desired_w, delta_w, res_w;
    logic signed [31:0] sprod_w;
    logic [16:0] q_w;
    logic signed [17:0] ramp_w;

    always_comb
    begin
        sprod_w   = act_reg[15] ? -$signed(mprod) : $signed(mprod);
        scaled_w  = (sprod_w + 32'sd2048) >>> 12;
        desired_w = 21'($signed(def_q_reg)) + 21'(scaled_w);
        delta_w   = desired_w - 21'($signed(held_q_reg));
        if (delta_w > $signed({6'b000000, step_reg}))
        begin
            delta_w = $signed({6'b000000, step_reg});
        end
        else if (delta_w < -$signed({6'b000000, step_reg}))
        begin
            delta_w = -$signed({6'b000000, step_reg});
        end
        res_w  = 21'($signed(held_q_reg)) + delta_w;
        q_w    = drsp.quotient[16:0];
        ramp_w = neg_reg ? 18'($signed(cap_q_reg)) - $signed({1'b0, q_w})
                         : 18'($signed(cap_q_reg)) + $signed({1'b0, q_w});
        case (tick_kind_reg)
            MODE_INIT:   tgt_w = cap_q_reg;
            MODE_RAMP:
            begin
                if (ramp_count_reg >= ticks_eff)
                    tgt_w = def_q_reg;
                else if (ramp_w > 18'sd32767)
                    tgt_w = 16'sh7fff;
                else if (ramp_w < -18'sd32768)
                    tgt_w = -16'sh8000;
                else
                    tgt_w = ramp_w[15:0];
            end
            MODE_POLICY:
            begin
                if (!tick_due_reg)
                    tgt_w = held_q_reg;
                else if (res_w > 21'sd32767)
                    tgt_w = 16'sh7fff;
                else if (res_w < -21'sd32768)
                    tgt_w = -16'sh8000;
                else
                    tgt_w = res_w[15:0];
            end
            default:     tgt_w = freeze_entry_reg ? held_q_reg : frz_rd;
        endcase
    end

    assign diff_w = 17'($signed(def_rd)) - 17'($signed(cap_rd));
    assign mag_w  = diff_w[16] ? 16'(-diff_w) : diff_w[15:0];

    // serial unit starts; a policy-due joint uses the multiplier, ramp the multiplier then the divider,
    // a policy tick begin uses the divider for the period step
    always_comb
    begin
        mstart = 1'b0;
        ma     = act_reg[15] ? 16'(-act_reg) : act_reg;
        mb     = scale_reg;
        if (state_reg == ST_CALC && op_reg == OP_JOINT && p_ok)
        begin
            if (tick_kind_reg == MODE_POLICY && tick_due_reg)
                mstart = 1'b1;
            if (tick_kind_reg == MODE_RAMP && ramp_count_reg < ticks_eff)
            begin
                mstart = 1'b1;
                ma     = mag_w;
                mb     = ramp_count_reg;
            end
        end
        if (state_reg == ST_CALC && begin_div_w)
        begin
            dreq.start    = 1'b1;
            dreq.dividend = {24'd0, period_count_reg} + 32'd1;
            dreq.divisor  = {8'd0, per_eff};
        end
        else
        begin
            dreq.start    = (state_reg == ST_WAIT) && mdone && (op_reg == OP_JOINT)
                         && (tick_kind_reg == MODE_RAMP);
            dreq.dividend = mprod + {17'd0, ticks_eff[15:1]};
            dreq.divisor  = ticks_eff;
        end
    end

    // tick begin mode update
    logic [1:0]  rm_n;
    logic [15:0] rc_n;
    logic [7:0]  pc_n;
    logic        fe_n;
    logic [15:0] rc_inc;

    always_comb
    begin
        rm_n   = run_mode_reg;
        rc_n   = ramp_count_reg;
        pc_n   = period_count_reg;
        fe_n   = 1'b0;
        kind_w = tick_kind_reg;
        due_w  = 1'b0;
        rc_inc = (ramp_count_reg == 16'hffff) ? ramp_count_reg : ramp_count_reg + 16'd1;
        if (estop_reg || (imu_reg && gz_reg > tilt_reg))
        begin
            if (run_mode_reg != MODE_FROZEN)
            begin
                fe_n = 1'b1;
                rm_n = MODE_FROZEN;
            end
            kind_w = MODE_FROZEN;
        end
        else
        begin
            case (run_mode_reg)
                MODE_INIT:
                begin
                    kind_w = MODE_INIT;
                    if (imu_reg)
                    begin
                        rm_n = MODE_RAMP;
                        rc_n = 16'd0;
                    end
                end
                MODE_RAMP:
                begin
                    kind_w = MODE_RAMP;
                    rc_n   = rc_inc;
                    if (rc_inc >= ticks_eff)
                    begin
                        rm_n = MODE_POLICY;
                        pc_n = 8'd0;
                    end
                end
                MODE_POLICY:
                begin
                    kind_w = MODE_POLICY;
                    due_w  = (period_count_reg == 8'd0);
                    // (period_count + 1) modulo period, from the divider
                    pc_n   = drsp.remainder[7:0];
                end
                default: kind_w = MODE_FROZEN;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_READ1;
            ST_READ1: state_next = ST_READ2;
            ST_READ2: state_next = ST_CALC;
            ST_CALC:
            begin
                if (begin_div_w ||
                    (op_reg == OP_JOINT && p_ok &&
                     ((tick_kind_reg == MODE_POLICY && tick_due_reg) ||
                      (tick_kind_reg == MODE_RAMP && ramp_count_reg < ticks_eff))))
                    state_next = ST_WAIT;
                else
                    state_next = ST_FIN;
            end
            ST_WAIT:
            begin
                if (use_div_w ? drsp.done : mdone)
                    state_next = ST_FIN;
            end
            ST_FIN:   if (out_free) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            run_mode_reg     <= MODE_INIT;
            tick_kind_reg    <= MODE_INIT;
            tick_due_reg     <= 1'b0;
            freeze_entry_reg <= 1'b0;
            ramp_count_reg   <= '0;
            period_count_reg <= '0;
            ovalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_fire)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
            if (fin_fire)
            begin
                case (op_reg)
                    OP_CAPTURE:
                    begin
                        if (last_reg)
                        begin
                            run_mode_reg     <= MODE_INIT;
                            tick_kind_reg    <= MODE_INIT;
                            tick_due_reg     <= 1'b0;
                            freeze_entry_reg <= 1'b0;
                            ramp_count_reg   <= '0;
                            period_count_reg <= '0;
                        end
                    end
                    OP_BEGIN:
                    begin
                        run_mode_reg     <= rm_n;
                        tick_kind_reg    <= kind_w;
                        tick_due_reg     <= due_w;
                        freeze_entry_reg <= fe_n;
                        ramp_count_reg   <= rc_n;
                        period_count_reg <= pc_n;
                    end
                    default: ;
                endcase
            end
        end
    end

    // request capture, memory read data and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            op_reg    <= s_axis_tdata[1:0];
            p_reg     <= s_axis_tdata[6:2];
            c_reg     <= s_axis_tdata[11:7];
            pos_reg   <= s_axis_tdata[27:12];
            act_reg   <= s_axis_tdata[43:28];
            gz_reg    <= s_axis_tdata[59:44];
            estop_reg <= s_axis_tuser[0];
            imu_reg   <= s_axis_tuser[1];
            last_reg  <= s_axis_tlast;
        end
        if (state_reg == ST_READ2)
            m_reg <= m_w;
        if (state_reg == ST_CALC)
        begin
            cap_q_reg  <= cap_rd;
            def_q_reg  <= def_rd;
            held_q_reg <= held_rd;
            neg_reg    <= diff_w[16];
        end
        if (fin_fire)
        begin
            olast_reg <= last_reg;
            case (op_reg)
                OP_LOAD:
                begin
                    omode_reg <= run_mode_reg;
                    odue_reg  <= 1'b0;
                    ovld_reg  <= 1'b0;
                    oidx_reg  <= '0;
                    otgt_reg  <= '0;
                end
                OP_CAPTURE:
                begin
                    omode_reg <= last_reg ? MODE_INIT : run_mode_reg;
                    odue_reg  <= 1'b0;
                    ovld_reg  <= 1'b0;
                    oidx_reg  <= '0;
                    otgt_reg  <= '0;
                end
                OP_BEGIN:
                begin
                    omode_reg <= kind_w;
                    odue_reg  <= due_w;
                    ovld_reg  <= 1'b0;
                    oidx_reg  <= '0;
                    otgt_reg  <= '0;
                end
                default:
                begin
                    omode_reg <= tick_kind_reg;
                    odue_reg  <= tick_due_reg;
                    ovld_reg  <= p_ok;
                    oidx_reg  <= p_ok ? m_reg : 5'd0;
                    otgt_reg  <= p_ok ? tgt_w : 16'sd0;
                end
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {1'b0, otgt_reg, oidx_reg, omode_reg};
    assign m_axis_tuser  = {ovld_reg, odue_reg};
    assign m_axis_tlast  = olast_reg;

    `include "joint_target_sequencer_top_defines.svh"

    `JTS_ASSERT_IMP(a_one_hot, 1'b1, $onehot(state_reg))
    `JTS_ASSERT_IMP(a_ready_idle, s_axis_tready, !ovalid_reg || state_reg == ST_IDLE)
    `JTS_ASSERT_NXT(a_fin_out, fin_fire, state_reg == ST_OUT)

endmodule
